/* hw/rtl/srle_pkg.sv */
package srle_pkg;

  localparam int ColourWidth = 8;
  localparam int TickWidth   = 8;
  localparam int LatchWidth  = 17;
  localparam int WordWidth   = 3 * ColourWidth;
  localparam int BitCntWidth = $clog2(WordWidth);

  localparam logic [BitCntWidth-1:0] LAST_BIT = BitCntWidth'(WordWidth - 1);

  localparam logic [1:0] CFG_SHORT_TICKS = 2'd0;
  localparam logic [1:0] CFG_LONG_TICKS  = 2'd1;
  localparam logic [1:0] CFG_RESET_TICKS = 2'd2;

  localparam logic [TickWidth-1:0]  SHORT_TICKS_RESET = 8'd30;
  localparam logic [TickWidth-1:0]  LONG_TICKS_RESET  = 8'd90;
  localparam logic [LatchWidth-1:0] RESET_TICKS_RESET = 17'd80000;

  typedef struct packed {
    logic [ColourWidth-1:0] red;
    logic [ColourWidth-1:0] green;
    logic [ColourWidth-1:0] blue;
    logic                   frame_start;
  } pixel_t;

  typedef struct packed {
    logic [TickWidth-1:0]  high_ticks;
    logic [LatchWidth-1:0] low_ticks;
    logic                  last;
  } pulse_t;

  typedef struct packed {
    logic [WordWidth-1:0] word;
    logic                 frame_start;
  } cmd_t;

  typedef struct packed {
    logic [TickWidth-1:0]  short_ticks;
    logic [TickWidth-1:0]  long_ticks;
    logic [LatchWidth-1:0] reset_ticks;
  } timing_t;

endpackage

/* hw/rtl/srle_front.sv */
module srle_front
  import srle_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_ready,
  input  pixel_t pixel,
  output logic   cmd_valid,
  input  logic   cmd_ready,
  output cmd_t   cmd
);

  logic held;
  cmd_t cmd_reg;

  assign pixel_ready = !held || cmd_ready;
  assign cmd_valid   = held;
  assign cmd         = cmd_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (pixel_ready) begin
      held <= pixel_valid;
    end
  end

  // Bytes go out green first, then red, then blue, most significant bit first.
  always_ff @(posedge clk) begin
    if (pixel_valid && pixel_ready) begin
      cmd_reg.word        <= {pixel.green, pixel.red, pixel.blue};
      cmd_reg.frame_start <= pixel.frame_start;
    end
  end

endmodule

/* hw/rtl/srle_queue.sv */
module srle_queue
  import srle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

/* hw/rtl/srle_back.sv */
module srle_back
  import srle_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  timing_t timing,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  cmd_t    cmd,
  output logic    pulse_valid,
  input  logic    pulse_ready,
  output pulse_t  pulse
);

  logic                   busy;
  logic                   latch_pending;
  logic [WordWidth-1:0]   word;
  logic [BitCntWidth-1:0] bit_cnt;
  logic                   out_valid;
  pulse_t                 out_reg;
  logic                   load;
  logic                   emit;
  logic                   cur_bit;

  assign cmd_ready   = !busy;
  assign load        = !busy && cmd_valid;
  assign emit        = busy && (!out_valid || pulse_ready);
  assign cur_bit     = word[WordWidth-1];
  assign pulse_valid = out_valid;
  assign pulse       = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pulse_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (emit && !latch_pending && bit_cnt == LAST_BIT) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word          <= cmd.word;
      latch_pending <= cmd.frame_start;
      bit_cnt       <= '0;
    end else if (emit) begin
      if (latch_pending) begin
        latch_pending      <= 1'b0;
        out_reg.high_ticks <= '0;
        out_reg.low_ticks  <= timing.reset_ticks;
        out_reg.last       <= 1'b0;
      end else begin
        word    <= {word[WordWidth-2:0], 1'b0};
        bit_cnt <= bit_cnt + 1'b1;
        out_reg.high_ticks <= cur_bit ? timing.long_ticks : timing.short_ticks;
        out_reg.low_ticks  <= LatchWidth'(cur_bit ? timing.short_ticks : timing.long_ticks);
        out_reg.last       <= (bit_cnt == LAST_BIT);
      end
    end
  end

endmodule

/* hw/rtl/serial_rgb_led_pulse_encoder_core.sv */
// One-wire RGB LED line encoder. Each pixel request carries red, green and
// blue bytes and a frame-start flag; the block answers with one pulse
// request per data bit, 24 in all, green byte first, each byte most
// significant bit first. A one is a long high and a short low, a zero a short
// high and a long low. A frame-start pixel is preceded by a latch pulse with
// zero high time and reset_ticks of low time. The last data pulse of a pixel
// carries last set.
// Timing registers are written through the cfg channel (index 0 short_ticks,
// 1 long_ticks, 2 reset_ticks); other indexes are ignored.
// The first pulse passes through the front register, the queue, the
// serialiser word register and the pulse register. The serialiser gives one
// pulse per cycle while the receiver keeps up, and takes the next pixel only
// after the last pulse of the current one. Two pixels can wait in the queue
// behind the serialiser, so the pixel side keeps taking requests while a
// pulse waits. When the receiver stalls, the pulse register holds its value
// and the stall spreads back to the pixel side once the queue is full.
// Reset empties the front stage, the queue and the serialiser and restores
// the timing registers to 30, 90 and 80000 ticks.
module serial_rgb_led_pulse_encoder_core
  import srle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  pixel_t                pixel,
  output logic                  pulse_valid,
  input  logic                  pulse_ready,
  output pulse_t                pulse,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [LatchWidth-1:0] cfg_data
);

  timing_t timing;
  logic    f_valid;
  logic    f_ready;
  cmd_t    f_cmd;
  logic    q_valid;
  logic    q_ready;
  cmd_t    q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.short_ticks <= SHORT_TICKS_RESET;
      timing.long_ticks  <= LONG_TICKS_RESET;
      timing.reset_ticks <= RESET_TICKS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SHORT_TICKS: timing.short_ticks <= cfg_data[TickWidth-1:0];
        CFG_LONG_TICKS:  timing.long_ticks  <= cfg_data[TickWidth-1:0];
        CFG_RESET_TICKS: timing.reset_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  srle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .cmd_valid   (f_valid),
    .cmd_ready   (f_ready),
    .cmd         (f_cmd)
  );

  srle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  srle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .timing      (timing),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .pulse_valid (pulse_valid),
    .pulse_ready (pulse_ready),
    .pulse       (pulse)
  );

endmodule

/* verif/serial_rgb_led_pulse_encoder_core_tb.sv */
module serial_rgb_led_pulse_encoder_core_tb;
  import srle_pkg::*;

  localparam logic [1:0] CFG_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT   = 1000000;
  localparam int         RANDOM_PIXELS = 130;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_ready;
  pixel_t                pixel = '0;
  logic                  pulse_valid;
  logic                  pulse_ready = 1'b0;
  pulse_t                pulse;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [LatchWidth-1:0] cfg_data = '0;

  logic [TickWidth-1:0]  tick_short = SHORT_TICKS_RESET;
  logic [TickWidth-1:0]  tick_long  = LONG_TICKS_RESET;
  logic [LatchWidth-1:0] latch_ticks = RESET_TICKS_RESET;

  pulse_t pulse_q[$];

  int mismatches     = 0;
  int pulses_checked = 0;
  int pixels_sent    = 0;
  int frames_sent    = 0;
  int reg_writes     = 0;
  int cycle_count    = 0;
  int stall_left     = 0;
  int calm_left      = 0;

  serial_rgb_led_pulse_encoder_core u_top (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .pulse_valid (pulse_valid),
    .pulse_ready (pulse_ready),
    .pulse       (pulse),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic pixel_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic fs);
    pixel_t px;
    px.red         = r;
    px.green       = g;
    px.blue        = b;
    px.frame_start = fs;
    return px;
  endfunction

  // Works out the pulse requests of one pixel under the current timing.
  function automatic void expect_pixel_pulses(input pixel_t px);
    logic [WordWidth-1:0] word;
    pulse_t               pl;
    word = {px.green, px.red, px.blue};
    if (px.frame_start) begin
      pl.high_ticks = '0;
      pl.low_ticks  = latch_ticks;
      pl.last       = 1'b0;
      pulse_q.push_back(pl);
    end
    for (int i = WordWidth - 1; i >= 0; i--) begin
      if (word[i]) begin
        pl.high_ticks = tick_long;
        pl.low_ticks  = LatchWidth'(tick_short);
      end else begin
        pl.high_ticks = tick_short;
        pl.low_ticks  = LatchWidth'(tick_long);
      end
      pl.last = (i == 0);
      pulse_q.push_back(pl);
    end
  endfunction

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: pulse %0d %s expected %0d, actual %0d",
               $time, pulses_checked, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    pulse_t want;
    if (!rst && pulse_valid && pulse_ready) begin
      if (pulse_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected pulse expected none, actual high %0d low %0d last %0d",
                 $time, pulse.high_ticks, pulse.low_ticks, pulse.last);
      end else begin
        want = pulse_q.pop_front();
        compare_field("high_ticks", 32'(want.high_ticks), 32'(pulse.high_ticks));
        compare_field("low_ticks", 32'(want.low_ticks), 32'(pulse.low_ticks));
        compare_field("last", 32'(want.last), 32'(pulse.last));
      end
      pulses_checked++;
    end
  end

  always @(negedge clk) begin
    int n;
    if (stall_left > 0) begin
      pulse_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (calm_left > 0) begin
      pulse_ready <= 1'b1;
      calm_left = calm_left - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      pulse_ready <= 1'b1;
      calm_left = $urandom_range(100, 300);
    end else if ($urandom_range(0, 5) == 0) begin
      n = idle_cycles();
      pulse_ready <= (n == 0);
      if (n > 0) stall_left = n - 1;
    end else begin
      pulse_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // The valid stays high after acceptance so that a following request can go
  // out on the next cycle; drain_pulses lowers it.
  task automatic send_pixel(input pixel_t px, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= px;
    do @(posedge clk); while (!pixel_ready);
    expect_pixel_pulses(px);
    pixels_sent++;
    if (px.frame_start) frames_sent++;
  endtask

  task automatic drain_pulses();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (pulse_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [LatchWidth-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SHORT_TICKS: tick_short  = data[TickWidth-1:0];
      CFG_LONG_TICKS:  tick_long   = data[TickWidth-1:0];
      CFG_RESET_TICKS: latch_ticks = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_reset_timing();
    send_pixel(make_pixel(8'h12, 8'h34, 8'h56, 1'b1), 0);
    send_pixel(make_pixel(8'hC3, 8'h3C, 8'h0F, 1'b0), 0);
    send_pixel(make_pixel(8'hF0, 8'h81, 8'h7E, 1'b0), 0);
    drain_pulses();
  endtask

  task automatic check_pixel_extremes();
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b1), 0);
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0), 1);
    send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 1'b1), 0);
    send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA, 1'b0), 2);
    send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 1'b0), 0);
    send_pixel(make_pixel(8'h80, 8'h01, 8'h80, 1'b1), 0);
    send_pixel(make_pixel(8'h01, 8'h80, 8'h01, 1'b1), 30);
    drain_pulses();
  endtask

  task automatic check_tick_extremes();
    write_reg(CFG_SHORT_TICKS, 17'd1);
    write_reg(CFG_LONG_TICKS, 17'd255);
    write_reg(CFG_RESET_TICKS, 17'd1);
    send_pixel(make_pixel(8'h0F, 8'hF0, 8'h3C, 1'b1), 0);
    send_pixel(make_pixel(8'hFF, 8'h00, 8'h81, 1'b0), 0);
    send_pixel(make_pixel(8'h00, 8'hFF, 8'h7E, 1'b1), 0);
    drain_pulses();
    write_reg(CFG_SHORT_TICKS, 17'd255);
    write_reg(CFG_LONG_TICKS, 17'd1);
    write_reg(CFG_RESET_TICKS, 17'h1FFFF);
    send_pixel(make_pixel(8'hA5, 8'h5A, 8'hC3, 1'b1), 0);
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b0), 3);
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1), 0);
    drain_pulses();
  endtask

  task automatic check_zero_ticks();
    write_reg(CFG_SHORT_TICKS, 17'd0);
    write_reg(CFG_LONG_TICKS, 17'd0);
    write_reg(CFG_RESET_TICKS, 17'd0);
    send_pixel(make_pixel(8'h96, 8'h69, 8'hE1, 1'b1), 0);
    send_pixel(make_pixel(8'h1E, 8'hD2, 8'h2D, 1'b0), 0);
    drain_pulses();
  endtask

  // Only the low byte of the short and long tick registers is kept, and index three is ignored.
  task automatic check_register_masking();
    write_reg(CFG_SHORT_TICKS, 17'h15A3C);
    write_reg(CFG_LONG_TICKS, 17'h1FF01);
    write_reg(CFG_RESET_TICKS, 17'h0ABCD);
    write_reg(CFG_UNUSED, 17'h00007);
    write_reg(CFG_UNUSED, 17'h1FFFF);
    send_pixel(make_pixel(8'h3C, 8'hC3, 8'h99, 1'b1), 0);
    send_pixel(make_pixel(8'h66, 8'h18, 8'hE7, 1'b0), 0);
    drain_pulses();
  endtask

  task automatic check_random_frames();
    int     sent;
    int     frame_len;
    bit     burst;
    pixel_t px;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_pulses();
        write_reg(CFG_SHORT_TICKS, LatchWidth'($urandom_range(0, 17'h1FFFF)));
        write_reg(CFG_LONG_TICKS, LatchWidth'($urandom_range(0, 17'h1FFFF)));
        write_reg(CFG_RESET_TICKS, LatchWidth'($urandom_range(0, 17'h1FFFF)));
        if ($urandom_range(0, 3) == 0)
          write_reg(CFG_UNUSED, LatchWidth'($urandom_range(0, 17'h1FFFF)));
      end
      frame_len = $urandom_range(1, 8);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < frame_len; i++) begin
        px.red   = ColourWidth'($urandom_range(0, 255));
        px.green = ColourWidth'($urandom_range(0, 255));
        px.blue  = ColourWidth'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
          px.frame_start = 1'($urandom_range(0, 1));
        else
          px.frame_start = (i == 0);
        send_pixel(px, burst ? 0 : idle_cycles());
        sent++;
      end
    end
    drain_pulses();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_reset_timing();
    check_pixel_extremes();
    check_tick_extremes();
    check_zero_ticks();
    check_register_masking();
    check_random_frames();
    repeat (20) @(posedge clk);
    mismatches += pulse_q.size();
    $display("Encoded %0d pixels in %0d frames and checked %0d pulses,", pixels_sent,
             frames_sent, pulses_checked);
    $display("with %0d timing register writes including zero, extreme and masked values.",
             reg_writes);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
